// ===== design/text_window_console_writer_defines.svh =====
// ----------------------------------------------------------------------------
// Text window console writer: assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef TEXT_WINDOW_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_WINDOW_CONSOLE_WRITER_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off during reset
`define TWCW_ASSERT_NOW(lbl, ant, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (cons)) \
        else $error("twcw same-cycle check failed");

// Next-cycle implication, sampled on i_clk, off during reset
`define TWCW_ASSERT_NEXT(lbl, ant, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (cons)) \
        else $error("twcw next-cycle check failed");

`endif

// ===== design/twcw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twcw_pkg
// Screen geometry, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package twcw_pkg;

    localparam int SCREEN_COLS = 80;
    localparam int SCREEN_ROWS = 25;
    localparam int TAB_WIDTH   = 4;

    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int CELL_W = 16;
    localparam int CELLS  = SCREEN_COLS * SCREEN_ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int TCNT_W = $clog2(TAB_WIDTH + 1);

    // actions
    localparam logic [1:0] ACT_PRINT  = 2'd0;
    localparam logic [1:0] ACT_CLEAR  = 2'd1;
    localparam logic [1:0] ACT_SETCUR = 2'd2;
    localparam logic [1:0] ACT_READ   = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_FIRST_COL = 2'd0;
    localparam logic [1:0] CFG_LAST_COL  = 2'd1;
    localparam logic [1:0] CFG_FIRST_ROW = 2'd2;
    localparam logic [1:0] CFG_LAST_ROW  = 2'd3;

    // character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_BLANK = 8'h20;

    typedef struct packed {
        logic wipe;
        logic latch;
        logic exec_bs;
        logic tab_load;
        logic put;
        logic adv;
        logic scr_rd;
        logic scr_wr;
        logic blank;
        logic fill_init;
        logic fill;
        logic set_cur;
        logic rd_issue;
        logic rd_cap;
    } t_cmd;

    typedef struct packed {
        logic [1:0] action;
        logic       is_nul;
        logic       is_bs;
        logic       is_lf;
        logic       is_tab;
        logic       rd_in_range;
        logic       need_scroll;
        logic       scr_empty;
        logic       scr_last;
        logic       col_last;
        logic       fill_last;
        logic       more_tab;
        logic       wipe_last;
    } t_stat;

endpackage

// ===== design/text_window_console_writer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_window_console_writer
// Text console over an 80x25 cell store with a configurable window.
// ----------------------------------------------------------------------------
// Usage: hold an item on i_action/i_character/i_attribute/i_col/i_row and
// raise start; it is taken at the edge where start is high and busy low.
// Exactly one result follows: o_done is high for one cycle with the
// window-relative cursor and, for a read, the cell character and attribute.
// The receiver cannot stall; sample the result while o_done is high.
// Window registers are to be written through i_cfg_we/i_cfg_idx/i_cfg_data
// only while idle; the block itself does not enforce this. A scroll fills
// each window cell above the bottom row from the cell below it, with a read
// and then a write, and then blanks the bottom row; clear writes each window
// cell. All cell traffic goes through the single write port and single read
// port of the store.
// After reset the whole store is wiped to zero with busy high.
// ----------------------------------------------------------------------------
module text_window_console_writer (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_idx,
    input  logic [twcw_pkg::COL_W-1:0] i_cfg_data,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 i_action,
    input  logic [7:0]                 i_character,
    input  logic [7:0]                 i_attribute,
    input  logic [twcw_pkg::COL_W-1:0] i_col,
    input  logic [twcw_pkg::ROW_W-1:0] i_row,
    output logic                       o_done,
    output logic [twcw_pkg::COL_W-1:0] o_cursor_col,
    output logic [twcw_pkg::ROW_W-1:0] o_cursor_row,
    output logic [7:0]                 o_cell_char,
    output logic [7:0]                 o_cell_attr
);
    import twcw_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    twcw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy),
        .o_done  (o_done)
    );

    twcw_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_action     (i_action),
        .i_character  (i_character),
        .i_attribute  (i_attribute),
        .i_col        (i_col),
        .i_row        (i_row),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_cursor_col (o_cursor_col),
        .o_cursor_row (o_cursor_row),
        .o_cell_char  (o_cell_char),
        .o_cell_attr  (o_cell_attr)
    );

endmodule

// ===== design/twcw_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twcw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module twcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/twcw_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twcw_ctrl
// Sequencer: wipes the store after reset and steps each item through
// the datapath (cell writes and reads, cursor moves, scroll and fill sweeps).
// ----------------------------------------------------------------------------
module twcw_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  twcw_pkg::t_stat i_stat,
    output twcw_pkg::t_cmd  o_cmd,
    output logic            busy,
    output logic            o_done
);
    import twcw_pkg::*;

    typedef enum logic [11:0] {
        S_WIPE   = 12'b0000_0000_0001,
        S_IDLE   = 12'b0000_0000_0010,
        S_EXEC   = 12'b0000_0000_0100,
        S_PUT    = 12'b0000_0000_1000,
        S_ADV    = 12'b0000_0001_0000,
        S_SCR_RD = 12'b0000_0010_0000,
        S_SCR_WR = 12'b0000_0100_0000,
        S_BLANK  = 12'b0000_1000_0000,
        S_FILL   = 12'b0001_0000_0000,
        S_RD     = 12'b0010_0000_0000,
        S_RD_CAP = 12'b0100_0000_0000,
        S_DONE   = 12'b1000_0000_0000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_WIPE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_WIPE: begin
                o_cmd.wipe = 1'b1;
                if (i_stat.wipe_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                case (i_stat.action)
                    ACT_PRINT: begin
                        if (i_stat.is_nul) begin
                            n_state = S_DONE;
                        end else if (i_stat.is_bs) begin
                            o_cmd.exec_bs = 1'b1;
                            n_state       = S_DONE;
                        end else if (i_stat.is_lf) begin
                            n_state = S_ADV;
                        end else begin
                            o_cmd.tab_load = i_stat.is_tab;
                            n_state        = S_PUT;
                        end
                    end
                    ACT_CLEAR: begin
                        o_cmd.fill_init = 1'b1;
                        n_state         = S_FILL;
                    end
                    ACT_SETCUR: begin
                        o_cmd.set_cur = 1'b1;
                        n_state       = S_DONE;
                    end
                    default: begin
                        n_state = i_stat.rd_in_range ? S_RD : S_DONE;
                    end
                endcase
            end
            S_PUT: begin
                o_cmd.put = 1'b1;
                n_state   = S_ADV;
            end
            S_ADV: begin
                o_cmd.adv = 1'b1;
                if (i_stat.need_scroll) begin
                    n_state = i_stat.scr_empty ? S_BLANK : S_SCR_RD;
                end else begin
                    n_state = i_stat.more_tab ? S_PUT : S_DONE;
                end
            end
            S_SCR_RD: begin
                o_cmd.scr_rd = 1'b1;
                n_state      = S_SCR_WR;
            end
            S_SCR_WR: begin
                o_cmd.scr_wr = 1'b1;
                n_state = (i_stat.col_last && i_stat.scr_last) ? S_BLANK : S_SCR_RD;
            end
            S_BLANK: begin
                o_cmd.blank = 1'b1;
                if (i_stat.col_last) n_state = i_stat.more_tab ? S_PUT : S_DONE;
            end
            S_FILL: begin
                o_cmd.fill = 1'b1;
                if (i_stat.fill_last) n_state = S_DONE;
            end
            S_RD: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = S_RD_CAP;
            end
            S_RD_CAP: begin
                o_cmd.rd_cap = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/twcw_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twcw_dp
// Datapath: window registers, cursor, sweep iterators, cell store and
// result registers.
// ----------------------------------------------------------------------------
module twcw_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_idx,
    input  logic [twcw_pkg::COL_W-1:0] i_cfg_data,
    input  logic [1:0]                 i_action,
    input  logic [7:0]                 i_character,
    input  logic [7:0]                 i_attribute,
    input  logic [twcw_pkg::COL_W-1:0] i_col,
    input  logic [twcw_pkg::ROW_W-1:0] i_row,
    input  twcw_pkg::t_cmd             i_cmd,
    output twcw_pkg::t_stat            o_stat,
    output logic [twcw_pkg::COL_W-1:0] o_cursor_col,
    output logic [twcw_pkg::ROW_W-1:0] o_cursor_row,
    output logic [7:0]                 o_cell_char,
    output logic [7:0]                 o_cell_attr
);
    import twcw_pkg::*;

    localparam logic [COL_W-1:0]  COL_MAX = COL_W'(SCREEN_COLS - 1);
    localparam logic [ROW_W-1:0]  ROW_MAX = ROW_W'(SCREEN_ROWS - 1);
    localparam logic [COL_W-1:0]  TAB_C   = COL_W'(TAB_WIDTH);
    localparam logic [ADDR_W-1:0] LAST_A  = ADDR_W'(CELLS - 1);

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [COL_W-1:0] c,
                                                    input logic [ROW_W-1:0] r);
        return ADDR_W'(ADDR_W'(r) * ADDR_W'(SCREEN_COLS)) + ADDR_W'(c);
    endfunction

    // configuration
    logic [COL_W-1:0] r_cfg_fc, r_cfg_lc;
    logic [ROW_W-1:0] r_cfg_fr, r_cfg_lr;
    // latched window, item, cursor, iterators
    logic [COL_W-1:0] r_wfc, r_wlc, r_cx, r_ic, r_col;
    logic [ROW_W-1:0] r_wfr, r_wlr, r_cy, r_ir, r_row;
    logic [1:0]       r_act;
    logic [7:0]       r_ch, r_at, r_out_char, r_out_attr;
    logic [TCNT_W-1:0] r_tcnt;
    logic [ADDR_W-1:0] r_wipe_addr;

    logic [COL_W-1:0] e_fc, e_lc0, e_lc, w1, cx_dec, cx_sat;
    logic [ROW_W-1:0] e_fr, e_lr0, e_lr, h1, cy_sat;
    logic             nl, at_edge, need_scroll;
    logic [7:0]       put_ch;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [CELL_W-1:0] ram_wdata, ram_rdata;

    // effective window from the registers
    always_comb begin
        e_fc  = (r_cfg_fc > COL_MAX) ? COL_MAX : r_cfg_fc;
        e_lc0 = (r_cfg_lc > COL_MAX) ? COL_MAX : r_cfg_lc;
        e_lc  = (e_lc0 < e_fc) ? e_fc : e_lc0;
        e_fr  = (r_cfg_fr > ROW_MAX) ? ROW_MAX : r_cfg_fr;
        e_lr0 = (r_cfg_lr > ROW_MAX) ? ROW_MAX : r_cfg_lr;
        e_lr  = (e_lr0 < e_fr) ? e_fr : e_lr0;
        cx_sat = (r_cx > (e_lc - e_fc)) ? (e_lc - e_fc) : r_cx;
        cy_sat = (r_cy > (e_lr - e_fr)) ? (e_lr - e_fr) : r_cy;
    end

    // cursor geometry on the latched window
    assign w1          = r_wlc - r_wfc;
    assign h1          = r_wlr - r_wfr;
    assign nl          = (r_ch == CH_LF);
    assign at_edge     = nl || (r_cx >= w1);
    assign need_scroll = at_edge && (r_cy >= h1);
    assign cx_dec      = (r_cx != '0) ? r_cx - COL_W'(1) : r_cx;
    assign put_ch      = (r_ch == CH_TAB) ? CH_BLANK : r_ch;

    // status toward the sequencer
    always_comb begin
        o_stat.action      = r_act;
        o_stat.is_nul      = (r_ch == CH_NUL);
        o_stat.is_bs       = (r_ch == CH_BS);
        o_stat.is_lf       = nl;
        o_stat.is_tab      = (r_ch == CH_TAB);
        o_stat.rd_in_range = (r_col <= COL_MAX) && (r_row <= ROW_MAX);
        o_stat.need_scroll = need_scroll;
        o_stat.scr_empty   = (r_wfr == r_wlr);
        o_stat.scr_last    = ((r_ir + ROW_W'(1)) == r_wlr);
        o_stat.col_last    = (r_ic == r_wlc);
        o_stat.fill_last   = (r_ic == r_wlc) && (r_ir == r_wlr);
        o_stat.more_tab    = (r_ch == CH_TAB) && (r_tcnt != '0);
        o_stat.wipe_last   = (r_wipe_addr == LAST_A);
    end

    // store ports
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = cell_addr(r_wfc + r_cx, r_wfr + r_cy);
        ram_wdata = {r_at, put_ch};
        ram_raddr = cell_addr(r_col, r_row);
        if (i_cmd.wipe) begin
            ram_we    = 1'b1;
            ram_waddr = r_wipe_addr;
            ram_wdata = '0;
        end else if (i_cmd.exec_bs) begin
            ram_we    = 1'b1;
            ram_waddr = cell_addr(r_wfc + cx_dec, r_wfr + r_cy);
            ram_wdata = {r_at, CH_BLANK};
        end else if (i_cmd.put) begin
            ram_we = 1'b1;
        end else if (i_cmd.scr_wr) begin
            ram_we    = 1'b1;
            ram_waddr = cell_addr(r_ic, r_ir);
            ram_wdata = ram_rdata;
        end else if (i_cmd.blank) begin
            ram_we    = 1'b1;
            ram_waddr = cell_addr(r_ic, r_wlr);
            ram_wdata = {r_at, CH_BLANK};
        end else if (i_cmd.fill) begin
            ram_we    = 1'b1;
            ram_waddr = cell_addr(r_ic, r_ir);
            ram_wdata = {r_at, r_ch};
        end
        if (i_cmd.scr_rd) begin
            ram_raddr = cell_addr(r_ic, r_ir + ROW_W'(1));
        end
    end

    twcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // configuration writes and cursor/wipe control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_fc    <= '0;
            r_cfg_lc    <= COL_W'(79);
            r_cfg_fr    <= '0;
            r_cfg_lr    <= ROW_W'(24);
            r_cx        <= '0;
            r_cy        <= '0;
            r_wipe_addr <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FIRST_COL: r_cfg_fc <= i_cfg_data;
                    CFG_LAST_COL:  r_cfg_lc <= i_cfg_data;
                    CFG_FIRST_ROW: r_cfg_fr <= i_cfg_data[ROW_W-1:0];
                    CFG_LAST_ROW:  r_cfg_lr <= i_cfg_data[ROW_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.wipe) r_wipe_addr <= r_wipe_addr + ADDR_W'(1);
            // cursor moves
            if (i_cmd.latch && (i_action == ACT_PRINT)) begin
                r_cx <= cx_sat;
                r_cy <= cy_sat;
            end
            if (i_cmd.exec_bs) r_cx <= cx_dec;
            if (i_cmd.adv && !need_scroll) begin
                if (!at_edge) begin
                    r_cx <= r_cx + COL_W'(1);
                end else begin
                    r_cx <= '0;
                    r_cy <= r_cy + ROW_W'(1);
                end
            end
            if (i_cmd.blank && (r_ic == r_wlc)) begin
                r_cx <= '0;
                r_cy <= h1;
            end
            if (i_cmd.fill && (r_ic == r_wlc) && (r_ir == r_wlr)) begin
                r_cx <= '0;
                r_cy <= '0;
            end
            if (i_cmd.set_cur && (r_col <= w1) && (r_row <= h1)) begin
                r_cx <= r_col;
                r_cy <= r_row;
            end
        end
    end

    // item capture, iterators, tab count, results
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_wfc      <= e_fc;
            r_wlc      <= e_lc;
            r_wfr      <= e_fr;
            r_wlr      <= e_lr;
            r_act      <= i_action;
            r_ch       <= i_character;
            r_at       <= i_attribute;
            r_col      <= i_col;
            r_row      <= i_row;
            r_out_char <= '0;
            r_out_attr <= '0;
        end
        if (i_cmd.tab_load) r_tcnt <= TCNT_W'(TAB_C - (r_cx % TAB_C));
        if (i_cmd.put && (r_tcnt != '0)) r_tcnt <= r_tcnt - TCNT_W'(1);
        if (i_cmd.fill_init || (i_cmd.adv && need_scroll)) begin
            r_ic <= r_wfc;
            r_ir <= r_wfr;
        end
        if (i_cmd.scr_wr || i_cmd.fill) begin
            if (r_ic == r_wlc) begin
                r_ic <= r_wfc;
                r_ir <= r_ir + ROW_W'(1);
            end else begin
                r_ic <= r_ic + COL_W'(1);
            end
        end
        if (i_cmd.blank) r_ic <= r_ic + COL_W'(1);
        if (i_cmd.rd_cap) begin
            r_out_char <= ram_rdata[7:0];
            r_out_attr <= ram_rdata[15:8];
        end
    end

    assign o_cursor_col = r_cx;
    assign o_cursor_row = r_cy;
    assign o_cell_char  = r_out_char;
    assign o_cell_attr  = r_out_attr;

endmodule

// ===== design/twcw_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twcw_chk
// Port-level checks of the console writer, bound to the top level.
// ----------------------------------------------------------------------------
`include "text_window_console_writer_defines.svh"

module twcw_chk (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       o_done,
    input logic [twcw_pkg::COL_W-1:0] o_cursor_col,
    input logic [twcw_pkg::ROW_W-1:0] o_cursor_row
);
    import twcw_pkg::*;

    // a result only shows while an item is in work
    `TWCW_ASSERT_NOW(a_done_busy, o_done, busy)
    // an accepted item keeps the block busy
    `TWCW_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    // one result per item, one cycle wide
    `TWCW_ASSERT_NEXT(a_done_pulse, o_done, !o_done && !busy)
    // the cursor is on the screen whenever a result shows
    `TWCW_ASSERT_NOW(a_cursor_range, o_done, (o_cursor_col < COL_W'(SCREEN_COLS)) && (o_cursor_row < ROW_W'(SCREEN_ROWS)))

endmodule

bind text_window_console_writer twcw_chk u_chk (.*);
